// ----- design/cfgmpd_pkg.sv -----
package cfgmpd_pkg;

    // Store geometry. Entries are grouped eight to a row so that a bitmap read is one row access.
    localparam int MAX_INSTR = 4096;
    localparam int ENTRY_W   = $clog2(MAX_INSTR);
    localparam int ROWS      = MAX_INSTR / 8;
    localparam int ROW_W     = ENTRY_W - 3;
    localparam int LEN_W     = 13;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_INSTR);

    // Operation codes.
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_INSTR   = 2'd1;
    localparam logic [1:0] OP_SWENTRY = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    // Instruction kinds.
    localparam logic [2:0] KIND_JUMP   = 3'd1;
    localparam logic [2:0] KIND_JUMPIF = 3'd2;
    localparam logic [2:0] KIND_RETURN = 3'd3;
    localparam logic [2:0] KIND_SWITCH = 3'd4;

    typedef struct packed {
        logic       back;
        logic [1:0] pred;
    } t_entry;

    typedef t_entry [7:0] t_row;

endpackage

// ----- design/cfg_merge_point_detector.sv -----
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+---------------------------------------
// in       | input     | i_in_valid / o_in_stall   | i_op, i_kind, i_target, i_byte_index
// out      | output    | o_out_valid / i_out_stall | o_merge_bits
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (instr_count)
//
// In an instruction transaction each counter update is a read step and a write step on the row
// store, and an instruction may update two entries.
// A switch-entry transaction updates at most one entry; a read transaction runs a read step and an output step.
// A clear transaction, and reset, run a clearing pass over all ROWS (512) rows, one row per cycle.
// The input is stalled whenever the sequencer is not idle; a finished read result waits in the
// output register, so a stalled output holds the sequencer only on the next read.
module cfg_merge_point_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_kind,
    input  logic signed [15:0] i_target,
    input  logic [8:0]  i_byte_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_merge_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD1   = 3'd2;
    localparam logic [2:0] S_WR1   = 3'd3;
    localparam logic [2:0] S_RD2   = 3'd4;
    localparam logic [2:0] S_WR2   = 3'd5;
    localparam logic [2:0] S_RDB   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam int AW = cfgmpd_pkg::ENTRY_W;
    localparam int RW = cfgmpd_pkg::ROW_W;
    localparam int LW = cfgmpd_pkg::LEN_W;

    // Row store: one 24-bit row holds the counters and backward flags of eight instructions.
    cfgmpd_pkg::t_row r_mem [cfgmpd_pkg::ROWS];
    cfgmpd_pkg::t_row r_rd_data;

    logic [2:0]    r_state, n_state;
    logic [LW-1:0] r_instr_count;
    logic [LW-1:0] r_position, n_position;
    logic [RW-1:0] r_clr_row, n_clr_row;
    logic [AW-1:0] r_addr1, n_addr1;
    logic [AW-1:0] r_addr2, n_addr2;
    logic          r_back, n_back;
    logic          r_upd2, n_upd2;
    logic [7:0]    r_mask, n_mask;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_bits, n_out_bits;

    logic             w_in_acc;
    logic [LW-1:0]    w_len;
    logic             w_tgt_ok;
    logic             w_tgt_back;
    logic             w_pos_ok;
    logic             w_next_ok;
    logic             w_falls;
    logic             w_is_jump;
    logic [LW-1:0]    w_pos_inc;
    logic             w_we;
    logic [RW-1:0]    w_waddr;
    logic [RW-1:0]    w_raddr;
    cfgmpd_pkg::t_row w_wdata;
    logic [AW-1:0]    w_cur;
    cfgmpd_pkg::t_entry w_old;
    cfgmpd_pkg::t_entry w_new;
    logic [7:0]       w_bits;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_merge_bits = r_out_bits;
    assign w_in_acc     = i_in_valid && !o_in_stall;

    // The effective list length is instr_count capped at the store depth.
    assign w_len = (r_instr_count < cfgmpd_pkg::MAX_LEN) ? r_instr_count : cfgmpd_pkg::MAX_LEN;

    // A target counts only when it is non-negative and inside the list.
    assign w_tgt_ok   = !i_target[15] && ($unsigned(i_target) < {3'b000, w_len});
    assign w_tgt_back = ({3'b000, r_position} > $unsigned(i_target));
    assign w_pos_ok   = (r_position < w_len);
    assign w_pos_inc  = r_position + LW'(1);
    assign w_next_ok  = (w_pos_inc < w_len);
    assign w_is_jump  = (i_kind == cfgmpd_pkg::KIND_JUMP) || (i_kind == cfgmpd_pkg::KIND_JUMPIF);
    assign w_falls    = (i_kind != cfgmpd_pkg::KIND_JUMP) && (i_kind != cfgmpd_pkg::KIND_RETURN)
                        && (i_kind != cfgmpd_pkg::KIND_SWITCH);

    // The shared read-modify-write unit: one saturating increment and flag merge per pass.
    assign w_cur = (r_state == S_WR2) ? r_addr2 : r_addr1;
    assign w_old = r_rd_data[w_cur[2:0]];
    always_comb begin
        w_new      = w_old;
        w_new.pred = (w_old.pred[1]) ? 2'd2 : (w_old.pred + 2'd1);
        w_new.back = w_old.back | ((r_state == S_WR1) && r_back);
        w_wdata    = r_rd_data;
        w_wdata[w_cur[2:0]] = w_new;
        w_we       = 1'b0;
        w_waddr    = w_cur[AW-1:3];
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_row;
            w_wdata = '0;
        end else if (r_state == S_WR1 || r_state == S_WR2) begin
            w_we = 1'b1;
        end
    end

    assign w_raddr = (r_state == S_RD2) ? r_addr2[AW-1:3] : r_addr1[AW-1:3];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    // A flag is a merge point when it is a backward target or has two predecessors.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_bits[k] = r_mask[k] && (r_rd_data[k].back || r_rd_data[k].pred[1]);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_position  = r_position;
        n_clr_row   = r_clr_row;
        n_addr1     = r_addr1;
        n_addr2     = r_addr2;
        n_back      = r_back;
        n_upd2      = r_upd2;
        n_mask      = r_mask;
        n_out_bits  = r_out_bits;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_CLEAR: begin
                n_clr_row = r_clr_row + RW'(1);
                if (r_clr_row == RW'(cfgmpd_pkg::ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_op)
                        cfgmpd_pkg::OP_CLEAR: begin
                            n_state    = S_CLEAR;
                            n_clr_row  = '0;
                            n_position = '0;
                        end
                        cfgmpd_pkg::OP_INSTR: begin
                            if (w_pos_ok) begin
                                n_position = w_pos_inc;
                                n_addr1    = i_target[AW-1:0];
                                n_addr2    = w_pos_inc[AW-1:0];
                                n_back     = w_tgt_back;
                                n_upd2     = w_next_ok && w_falls;
                                if (w_is_jump && w_tgt_ok) begin
                                    n_state = S_RD1;
                                end else if (w_next_ok && w_falls) begin
                                    n_state = S_RD2;
                                end
                            end
                        end
                        cfgmpd_pkg::OP_SWENTRY: begin
                            n_addr1 = i_target[AW-1:0];
                            n_back  = 1'b0;
                            n_upd2  = 1'b0;
                            if (w_tgt_ok) begin
                                n_state = S_RD1;
                            end
                        end
                        cfgmpd_pkg::OP_READ: begin
                            n_addr1 = {i_byte_index[RW-1:0], 3'b000};
                            for (int k = 0; k < 8; k++) begin
                                n_mask[k] = ({1'b0, i_byte_index, 3'(k)} < w_len);
                            end
                            n_state = S_RDB;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD1: n_state = S_WR1;
            S_WR1: n_state = r_upd2 ? S_RD2 : S_IDLE;
            S_RD2: n_state = S_WR2;
            S_WR2: n_state = S_IDLE;
            S_RDB: n_state = S_OUT;
            S_OUT: begin
                // The read address is held, so the row data stays put while the output is full.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_bits  = w_bits;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_row     <= '0;
            r_position    <= '0;
            r_instr_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_position  <= n_position;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_instr_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr1    <= n_addr1;
        r_addr2    <= n_addr2;
        r_back     <= n_back;
        r_upd2     <= n_upd2;
        r_mask     <= n_mask;
        r_out_bits <= n_out_bits;
    end

    // A new result only ever comes from the output step of a read.
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("output valid rose outside the read output step");

    // The store is written only by the clearing pass or by an update write step.
    a_write_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_WR1 || r_state == S_WR2))
        else $error("store written outside a write step");

    // An instruction inside the list advances the position by one.
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_op == cfgmpd_pkg::OP_INSTR && w_pos_ok)
        |=> r_position == $past(r_position) + LW'(1))
        else $error("position did not advance on an instruction");

    // The position never passes the store depth.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= cfgmpd_pkg::MAX_LEN)
        else $error("position beyond store depth");

endmodule
